[rtl/lpht_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the linear probing hash table.
// No dependencies; used by lpht_probe and linear_probe_hash_table.
package lpht_pkg;

  // Field widths of one transaction
  localparam int unsigned KEY_W       = 48;
  localparam int unsigned SIZE_W      = 32;
  localparam int unsigned ACT_W       = 2;
  localparam int unsigned STAT_W      = 2;
  localparam int unsigned IN_TDATA_W  = 88;  // 82 payload bits, zero-filled to bytes
  localparam int unsigned OUT_TDATA_W = 40;  // 34 payload bits, zero-filled to bytes

  // Home slot is taken from the key bits at and above this bit
  localparam int unsigned HOME_SHIFT  = 12;
  localparam int unsigned QUO_W       = KEY_W - HOME_SHIFT;

  // Default slot count
  localparam int unsigned CAPACITY_DEF = 256;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd1;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd2;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

  // Slot marks
  localparam logic [1:0] MARK_EMPTY = 2'd0;
  localparam logic [1:0] MARK_USED  = 2'd1;
  localparam logic [1:0] MARK_TOMB  = 2'd2;

  // One slot of the table memory
  typedef struct packed {
    logic [1:0]        mark;
    logic [KEY_W-1:0]  key;
    logic [SIZE_W-1:0] size;
  } slot_t;

  // Finished result handed from the probe engine to the output stage
  typedef struct packed {
    logic              valid;
    logic [STAT_W-1:0] status;
    logic [SIZE_W-1:0] size;
  } res_t;

endpackage

[rtl/lpht_ram.sv]
`timescale 1ns / 1ps
// Simple dual-port synchronous RAM: one write port, one read port,
// read data registered. No dependencies.
module lpht_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 82
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/lpht_probe.sv]
`timescale 1ns / 1ps
// Probe engine: clearing pass, home slot computation, linear probe over the
// slot memory and read-modify-write of the claimed or hit slot. Uses lpht_pkg.
module lpht_probe #(
  parameter int unsigned CAPACITY = lpht_pkg::CAPACITY_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [lpht_pkg::ACT_W-1:0]    in_action,
  input  logic [lpht_pkg::KEY_W-1:0]    in_key,
  input  logic [lpht_pkg::SIZE_W-1:0]   in_size,
  output lpht_pkg::res_t                res,
  input  logic                          res_ready,
  output logic                          wr_en,
  output logic [$clog2(CAPACITY)-1:0]   wr_addr,
  output lpht_pkg::slot_t               wr_data,
  output logic [$clog2(CAPACITY)-1:0]   rd_addr,
  input  lpht_pkg::slot_t               rd_data
);

  localparam int unsigned SLOT_W     = $clog2(CAPACITY);
  localparam int unsigned OCC_W      = $clog2(CAPACITY + 1);
  localparam bit          POW2       = (CAPACITY & (CAPACITY - 1)) == 0;
  localparam int unsigned DIGIT      = 4;
  localparam int unsigned HASH_STEPS = lpht_pkg::QUO_W / DIGIT;
  localparam int unsigned HSTEP_W    = $clog2(HASH_STEPS);

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(CAPACITY - 1);
  localparam logic [SLOT_W:0]   CAP_EXT   = (SLOT_W + 1)'(CAPACITY);
  localparam logic [OCC_W-1:0]  OCC_FULL  = OCC_W'(CAPACITY);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_HASH  = 5'b00100,
    S_PROBE = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t                            state;
  logic [SLOT_W-1:0]                 cur;
  logic [SLOT_W-1:0]                 cnt;
  logic [OCC_W-1:0]                  occ;
  logic [lpht_pkg::ACT_W-1:0]        act;
  logic [lpht_pkg::KEY_W-1:0]        key;
  logic [lpht_pkg::SIZE_W-1:0]       size;
  logic [lpht_pkg::QUO_W-1:0]        hq;
  logic [SLOT_W-1:0]                 hrem;
  logic [HSTEP_W-1:0]                hstep;
  logic [lpht_pkg::STAT_W-1:0]       res_status;
  logic [lpht_pkg::SIZE_W-1:0]       res_size;

  logic [SLOT_W-1:0] cur_inc;
  logic [SLOT_W-1:0] home_pow2;
  logic [SLOT_W-1:0] hrem_next;
  logic              ins;
  logic              is_used;
  logic              key_match;
  logic              last_probe;
  logic              full;
  logic              act_valid;

  // Probe decode
  always_comb begin
    cur_inc    = (cur == LAST_SLOT) ? '0 : cur + 1'b1;
    home_pow2  = in_key[lpht_pkg::HOME_SHIFT +: SLOT_W];
    ins        = act == lpht_pkg::ACT_INSERT;
    is_used    = rd_data.mark == lpht_pkg::MARK_USED;
    key_match  = is_used && (rd_data.key == key);
    last_probe = cnt == LAST_SLOT;
    full       = occ == OCC_FULL;
    act_valid  = in_action inside {lpht_pkg::ACT_INSERT, lpht_pkg::ACT_LOOKUP,
                                   lpht_pkg::ACT_REMOVE};
  end

  // Home slot remainder: shift in DIGIT key bits per cycle, reduce by CAPACITY
  always_comb begin
    logic [SLOT_W:0] t;
    hrem_next = hrem;
    for (int i = 0; i < DIGIT; i++) begin
      t = {hrem_next, hq[lpht_pkg::QUO_W-1-i]};
      if (t >= CAP_EXT) begin
        t = t - CAP_EXT;
      end
      hrem_next = t[SLOT_W-1:0];
    end
  end

  // Memory port control
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cur;
    wr_data = rd_data;
    rd_addr = cur_inc;
    case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_data = '0;
      end
      S_IDLE: begin
        rd_addr = home_pow2;
      end
      S_HASH: begin
        rd_addr = hrem_next;
      end
      S_PROBE: begin
        // Claim a free slot on insert, or tombstone a removed hit
        if (ins && !is_used) begin
          wr_en        = 1'b1;
          wr_data.mark = lpht_pkg::MARK_USED;
          wr_data.key  = key;
          wr_data.size = size;
        end else if (!ins && key_match && act == lpht_pkg::ACT_REMOVE) begin
          wr_en        = 1'b1;
          wr_data.mark = lpht_pkg::MARK_TOMB;
        end
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  assign in_ready   = state == S_IDLE;
  assign res.valid  = state == S_DONE;
  assign res.status = res_status;
  assign res.size   = res_size;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      cur   <= '0;
      occ   <= '0;
    end else begin
      case (state)
        // Sweep every slot to empty after reset
        S_CLEAR: begin
          cur <= cur_inc;
          if (cur == LAST_SLOT) begin
            state <= S_IDLE;
          end
        end
        // Take a transaction; finish invalid actions and inserts into a full table
        S_IDLE: begin
          if (in_valid) begin
            act      <= in_action;
            key      <= in_key;
            size     <= in_size;
            cnt      <= '0;
            hq       <= in_key[lpht_pkg::KEY_W-1:lpht_pkg::HOME_SHIFT];
            hrem     <= '0;
            hstep    <= '0;
            res_size <= '0;
            if (!act_valid) begin
              res_status <= lpht_pkg::ST_MISS;
              state      <= S_DONE;
            end else if (in_action == lpht_pkg::ACT_INSERT && full) begin
              res_status <= lpht_pkg::ST_FULL;
              state      <= S_DONE;
            end else if (POW2) begin
              cur   <= home_pow2;
              state <= S_PROBE;
            end else begin
              state <= S_HASH;
            end
          end
        end
        // Reduce the shifted key modulo the capacity
        S_HASH: begin
          hq    <= {hq[lpht_pkg::QUO_W-DIGIT-1:0], DIGIT'(0)};
          hrem  <= hrem_next;
          hstep <= hstep + 1'b1;
          if (hstep == HSTEP_W'(HASH_STEPS - 1)) begin
            cur   <= hrem_next;
            state <= S_PROBE;
          end
        end
        // Check one slot per cycle; the next slot is already being read
        S_PROBE: begin
          if (ins && !is_used) begin
            occ        <= occ + 1'b1;
            res_status <= lpht_pkg::ST_OK;
            state      <= S_DONE;
          end else if (!ins && key_match) begin
            res_status <= lpht_pkg::ST_OK;
            res_size   <= rd_data.size;
            if (act == lpht_pkg::ACT_REMOVE && occ != '0) begin
              occ <= occ - 1'b1;
            end
            state <= S_DONE;
          end else if (!ins && (rd_data.mark == lpht_pkg::MARK_EMPTY || last_probe)) begin
            res_status <= lpht_pkg::ST_MISS;
            state      <= S_DONE;
          end else begin
            cur <= cur_inc;
            cnt <= cnt + 1'b1;
          end
        end
        // Hold the result until the output stage takes it
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= OCC_FULL)
    else $error("occupancy above capacity");

  a_probe_range: assert property (@(posedge clk) disable iff (rst)
    state == S_PROBE |-> cur <= LAST_SLOT)
    else $error("probe slot out of range");

  a_write_window: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == S_CLEAR || state == S_PROBE))
    else $error("slot write outside clear or probe");

  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_PROBE && wr_en && ins) |=> occ == $past(occ) + 1'b1)
    else $error("insert did not bump occupancy");

  a_full_only_insert: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && res_status == lpht_pkg::ST_FULL) |->
      (act == lpht_pkg::ACT_INSERT && occ == OCC_FULL))
    else $error("full status without a full table");

endmodule

[rtl/linear_probe_hash_table.sv]
`timescale 1ns / 1ps
// Top level of the linear probing hash table: stream ports, output register.
// Depends on lpht_pkg, lpht_probe and lpht_ram.

// Maps a 48-bit block address to a 32-bit allocation size in CAPACITY slots
// of open addressing with linear probing and tombstones. Each transaction is
// one insert, lookup or remove and returns exactly one status and size. One
// transaction is handled at a time: the probe starts at the home slot, and
// each further slot probed lengthens it, since the slot memory is read one
// entry per cycle with registered read data. When CAPACITY is not a power of
// two the home slot is reduced modulo CAPACITY four key bits per cycle before
// the probe starts. After reset the block sweeps every slot of the slot
// memory to empty, with s_axis_tready low. A finished result waits in the
// output register while the next transaction is taken.
module linear_probe_hash_table #(
  parameter int unsigned CAPACITY = lpht_pkg::CAPACITY_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [1:0] action, [49:2] block_address, [81:50] block_size, [87:82] zero
  input  logic [lpht_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [1:0] status, [33:2] size_out, [39:34] zero
  output logic [lpht_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

  localparam int unsigned SLOT_W = $clog2(CAPACITY);
  localparam int unsigned PAD_W  = lpht_pkg::OUT_TDATA_W - lpht_pkg::STAT_W -
                                   lpht_pkg::SIZE_W;

  lpht_pkg::res_t  res;
  logic            res_ready;
  logic            wr_en;
  logic [SLOT_W-1:0] wr_addr;
  logic [SLOT_W-1:0] rd_addr;
  lpht_pkg::slot_t wr_data;
  lpht_pkg::slot_t rd_data;

  lpht_probe #(
    .CAPACITY (CAPACITY)
  ) u_probe (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_action (s_axis_tdata[1:0]),
    .in_key    (s_axis_tdata[49:2]),
    .in_size   (s_axis_tdata[81:50]),
    .res       (res),
    .res_ready (res_ready),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  lpht_ram #(
    .DEPTH (CAPACITY),
    .WIDTH ($bits(lpht_pkg::slot_t))
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Output register: load when empty or being drained
  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res.valid && res_ready) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && res_ready) begin
      m_axis_tdata <= {PAD_W'(0), res.size, res.status};
    end
  end

endmodule
